// ----- src/grcc_pkg.sv -----
package grcc_pkg;

   // Field widths fixed by the stream format.
   localparam int unsigned COORD_W      = 10;
   localparam int unsigned CNT_W        = 19;
   localparam int unsigned WORD_BITS    = 64;
   localparam int unsigned LANE_W       = 6;
   localparam int unsigned KW           = COORD_W - LANE_W;
   localparam int unsigned POP_W        = 7;
   localparam int unsigned REQ_DATA_W   = 40;
   localparam int unsigned RSP_DATA_W   = 40;
   localparam int unsigned CSR_ADDR_W   = 1;
   localparam int unsigned CSR_DATA_W   = 10;
   localparam int unsigned MAX_SIDE_DEF = 512;

   localparam logic [COORD_W-1:0] BOARD_RESET = 10'd512;

   localparam logic [CSR_ADDR_W-1:0] CSR_BOARD_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOARD_HEIGHT = 1'b1;

   typedef enum logic [0:0] {
      OP_CLEAR = 1'b0,
      OP_COVER = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_SETUP,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic clr_en;
   } bm_ctrl_type;

   typedef struct packed {
      logic             busy;
      logic             pop_valid;
      logic [POP_W-1:0] pop_count;
   } bm_stat_type;

   // Adder tree: six levels, each over independent pairs.
   function automatic logic [POP_W-1:0] popcount64(input logic [WORD_BITS-1:0] v);
      logic [1:0] c2 [32];
      logic [2:0] c4 [16];
      logic [3:0] c8 [8];
      logic [4:0] c16 [4];
      logic [5:0] c32 [2];
      for (int i = 0; i < 32; i++) c2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      for (int i = 0; i < 16; i++) c4[i] = {1'b0, c2[2*i]} + {1'b0, c2[2*i+1]};
      for (int i = 0; i < 8; i++) c8[i] = {1'b0, c4[2*i]} + {1'b0, c4[2*i+1]};
      for (int i = 0; i < 4; i++) c16[i] = {1'b0, c8[2*i]} + {1'b0, c8[2*i+1]};
      for (int i = 0; i < 2; i++) c32[i] = {1'b0, c16[2*i]} + {1'b0, c16[2*i+1]};
      return {1'b0, c32[0]} + {1'b0, c32[1]};
   endfunction

endpackage

// ----- src/grcc_bitmap.sv -----
module grcc_bitmap #(
   parameter int unsigned DEPTH = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  grcc_pkg::bm_ctrl_type                 ctrl,
   input  logic [$clog2(DEPTH)-1:0]              addr,
   input  logic [grcc_pkg::WORD_BITS-1:0]        mask,
   output grcc_pkg::bm_stat_type                 stat
);

   localparam int unsigned ADDR_W = $clog2(DEPTH);

   logic [grcc_pkg::WORD_BITS-1:0] mem [DEPTH];
   logic [grcc_pkg::WORD_BITS-1:0] q_ff;
   logic                           v1_ff;
   logic                           v1_in;
   logic [ADDR_W-1:0]              addr1_ff;
   logic [grcc_pkg::WORD_BITS-1:0] mask1_ff;
   logic                           pop_valid_ff;
   logic [grcc_pkg::POP_W-1:0]     pop_count_ff;
   logic [grcc_pkg::POP_W-1:0]     pop_count_in;

   logic                           wr_en;
   logic [ADDR_W-1:0]              wr_addr;
   logic [grcc_pkg::WORD_BITS-1:0] wr_data;

   // A sweep write and a write-back never share a cycle: sweeps run only
   // while the read pipeline is empty.
   assign wr_en   = ctrl.clr_en | v1_ff;
   assign wr_addr = v1_ff ? addr1_ff : addr;
   assign wr_data = v1_ff ? (q_ff | mask1_ff) : '0;

   assign v1_in        = ctrl.rd_en;
   assign pop_count_in = grcc_pkg::popcount64(mask1_ff & ~q_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         q_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         pop_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         pop_valid_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr1_ff     <= addr;
      mask1_ff     <= mask;
      pop_count_ff <= pop_count_in;
   end

   assign stat.busy      = v1_ff;
   assign stat.pop_valid = pop_valid_ff;
   assign stat.pop_count = pop_count_ff;

endmodule

// ----- src/grid_rectangle_cover_count_top.sv -----
// Rectangle item: accept, setup, one 64-bit word read per cycle over the words touched
//   (rows times words per row), then read-modify-write drain and result; one item at a time.
// Clear item: accept, setup, one word zeroed per cycle up to the highest word written since
//   the last clear, close the pass, post the result. A result not yet taken holds the next.
// Reset is synchronous; afterwards a pass zeroes all MAX_SIDE * ceil(MAX_SIDE/64) words
//   (4096 writes at MAX_SIDE = 512) before the first beat is taken.
module grid_rectangle_cover_count_top #(
   parameter int unsigned MAX_SIDE = grcc_pkg::MAX_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // x_first, y_first, x_second, y_second (10 bits each, from bit 0 up)
   input  logic [grcc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // opcode
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // newly_covered (19 bits), free_cells (19 bits), 2 zero bits
   output logic [grcc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [grcc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [grcc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned COORD_W    = grcc_pkg::COORD_W;
   localparam int unsigned KW         = grcc_pkg::KW;
   localparam int unsigned LANE_W     = grcc_pkg::LANE_W;
   localparam int unsigned WB         = grcc_pkg::WORD_BITS;
   localparam int unsigned CNT_W      = grcc_pkg::CNT_W;
   localparam int unsigned SIDE_W     = $clog2(MAX_SIDE + 1);
   localparam int unsigned CW         = (SIDE_W > COORD_W) ? SIDE_W : COORD_W;
   localparam int unsigned FC_W       = 2 * SIDE_W;
   localparam int unsigned WPR        = (MAX_SIDE + 63) / 64;
   localparam int unsigned TOTAL      = MAX_SIDE * WPR;
   localparam int unsigned ADDR_W     = $clog2(TOTAL);
   localparam int unsigned BOARD_EFF  = (512 > MAX_SIDE) ? MAX_SIDE : 512;
   localparam logic [FC_W-1:0]     RESET_FREE = FC_W'(BOARD_EFF * BOARD_EFF);
   localparam logic [ADDR_W-1:0]   WPR_A      = ADDR_W'(WPR);
   localparam logic [ADDR_W:0]     TOTAL_A    = (ADDR_W + 1)'(TOTAL);
   localparam logic [CW-1:0]       MAX_C      = CW'(MAX_SIDE);

   function automatic logic [SIDE_W-1:0] eff_side(input logic [COORD_W-1:0] v);
      logic [CW-1:0] e;
      e = CW'(v);
      if (e == '0) begin
         e = CW'(1);
      end else if (e > MAX_C) begin
         e = MAX_C;
      end
      return SIDE_W'(e);
   endfunction

   // Clamp to 1..lim and convert to a zero-based index.
   function automatic logic [COORD_W-1:0] clamp_idx(input logic [COORD_W-1:0] v,
                                                    input logic [SIDE_W-1:0] lim);
      logic [CW-1:0] e;
      e = CW'(v);
      if (e == '0) begin
         e = CW'(1);
      end else if (e > CW'(lim)) begin
         e = CW'(lim);
      end
      return COORD_W'(e - CW'(1));
   endfunction

   grcc_pkg::state_type   state_ff, state_in;
   grcc_pkg::bm_ctrl_type ctrl;
   grcc_pkg::bm_stat_type stat;
   grcc_pkg::op_type      op_ff, op_in;

   logic [COORD_W-1:0] board_width_ff, board_width_in;
   logic [COORD_W-1:0] board_height_ff, board_height_in;
   logic [COORD_W-1:0] xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic [COORD_W-1:0] x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  row_base_ff, row_base_in;
   logic [ADDR_W:0]    hw_ff, hw_in;
   logic               reply_ff, reply_in;
   logic [FC_W-1:0]    wh_ff, wh_in;
   logic [FC_W-1:0]    acc_ff, acc_in;
   logic [FC_W-1:0]    free_count_ff, free_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   rsp_cov_ff, rsp_cov_in;
   logic [CNT_W-1:0]   rsp_free_ff, rsp_free_in;

   logic [SIDE_W-1:0]  w_eff, h_eff;
   logic [COORD_W-1:0] cxa, cya, cxb, cyb, sx0, sx1, sy0, sy1;
   logic [ADDR_W+COORD_W-1:0] base_prod;
   logic [KW-1:0]      k0, k1;
   logic [LANE_W-1:0]  lo, hi;
   logic [WB-1:0]      mask;
   logic               sweep_more;
   logic               last_issue;
   logic               finish_go;
   logic [ADDR_W:0]    issue_next;
   logic [FC_W-1:0]    free_next;

   assign k0         = x0_ff[COORD_W-1:LANE_W];
   assign k1         = x1_ff[COORD_W-1:LANE_W];
   assign sweep_more = {1'b0, addr_ff} < hw_ff;
   assign last_issue = (k_ff == k1) && (row_ff == y1_ff);
   assign finish_go  = !rsp_valid_ff || rsp_tready;
   assign issue_next = {1'b0, addr_ff} + (ADDR_W + 1)'(1);
   assign free_next  = (acc_ff > free_count_ff) ? '0 : free_count_ff - acc_ff;

   assign lo   = (k_ff == k0) ? x0_ff[LANE_W-1:0] : '0;
   assign hi   = (k_ff == k1) ? x1_ff[LANE_W-1:0] : '1;
   assign mask = ({WB{1'b1}} << lo) & ({WB{1'b1}} >> (6'd63 - hi));

   // Corner ordering and clamping for the setup cycle.
   always_comb begin
      w_eff     = eff_side(board_width_ff);
      h_eff     = eff_side(board_height_ff);
      cxa       = clamp_idx(xa_ff, w_eff);
      cxb       = clamp_idx(xb_ff, w_eff);
      cya       = clamp_idx(ya_ff, h_eff);
      cyb       = clamp_idx(yb_ff, h_eff);
      sx0       = (cxa < cxb) ? cxa : cxb;
      sx1       = (cxa < cxb) ? cxb : cxa;
      sy0       = (cya < cyb) ? cya : cyb;
      sy1       = (cya < cyb) ? cyb : cya;
      base_prod = {{ADDR_W{1'b0}}, sy0} * {{COORD_W{1'b0}}, WPR_A};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         grcc_pkg::ST_SWEEP: begin
            if (!sweep_more) begin
               state_in = reply_ff ? grcc_pkg::ST_FINISH : grcc_pkg::ST_IDLE;
            end
         end
         grcc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = grcc_pkg::ST_SETUP;
            end
         end
         grcc_pkg::ST_SETUP: begin
            state_in = (op_ff == grcc_pkg::OP_CLEAR) ? grcc_pkg::ST_SWEEP : grcc_pkg::ST_RUN;
         end
         grcc_pkg::ST_RUN: begin
            if (last_issue) begin
               state_in = grcc_pkg::ST_DRAIN;
            end
         end
         grcc_pkg::ST_DRAIN: begin
            if (!stat.busy && !stat.pop_valid) begin
               state_in = grcc_pkg::ST_FINISH;
            end
         end
         grcc_pkg::ST_FINISH: begin
            if (finish_go) begin
               state_in = grcc_pkg::ST_IDLE;
            end
         end
         default: state_in = grcc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == grcc_pkg::ST_IDLE);
      ctrl.rd_en   = (state_ff == grcc_pkg::ST_RUN);
      ctrl.clr_en  = (state_ff == grcc_pkg::ST_SWEEP) && sweep_more;
   end

   always_comb begin
      op_in           = op_ff;
      board_width_in  = board_width_ff;
      board_height_in = board_height_ff;
      xa_in           = xa_ff;
      ya_in           = ya_ff;
      xb_in           = xb_ff;
      yb_in           = yb_ff;
      x0_in           = x0_ff;
      x1_in           = x1_ff;
      y1_in           = y1_ff;
      row_in          = row_ff;
      k_in            = k_ff;
      addr_in         = addr_ff;
      row_base_in     = row_base_ff;
      hw_in           = hw_ff;
      reply_in        = reply_ff;
      wh_in           = wh_ff;
      acc_in          = acc_ff;
      free_count_in   = free_count_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_cov_in      = rsp_cov_ff;
      rsp_free_in     = rsp_free_ff;

      if (csr_we) begin
         unique case (csr_addr)
            grcc_pkg::CSR_BOARD_WIDTH:  board_width_in  = csr_wdata;
            grcc_pkg::CSR_BOARD_HEIGHT: board_height_in = csr_wdata;
            default: ;
         endcase
      end

      if (stat.pop_valid) begin
         acc_in = acc_ff + FC_W'(stat.pop_count);
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         grcc_pkg::ST_SWEEP: begin
            if (sweep_more) begin
               addr_in = addr_ff + ADDR_W'(1);
               // The last word of the pass drops the mark, since the address may wrap.
               if (issue_next >= hw_ff) begin
                  hw_in = '0;
               end
            end else begin
               hw_in = '0;
            end
         end
         grcc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in = grcc_pkg::op_type'(req_tuser[0]);
               xa_in = req_tdata[COORD_W-1:0];
               ya_in = req_tdata[2*COORD_W-1:COORD_W];
               xb_in = req_tdata[3*COORD_W-1:2*COORD_W];
               yb_in = req_tdata[4*COORD_W-1:3*COORD_W];
            end
         end
         grcc_pkg::ST_SETUP: begin
            x0_in       = sx0;
            x1_in       = sx1;
            y1_in       = sy1;
            row_in      = sy0;
            k_in        = sx0[COORD_W-1:LANE_W];
            row_base_in = base_prod[ADDR_W-1:0];
            wh_in       = {{SIDE_W{1'b0}}, w_eff} * {{SIDE_W{1'b0}}, h_eff};
            acc_in      = '0;
            reply_in    = 1'b1;
            if (op_ff == grcc_pkg::OP_CLEAR) begin
               addr_in = '0;
            end else begin
               addr_in = base_prod[ADDR_W-1:0] + ADDR_W'(sx0[COORD_W-1:LANE_W]);
            end
         end
         grcc_pkg::ST_RUN: begin
            if (issue_next > hw_ff) begin
               hw_in = issue_next;
            end
            if (k_ff == k1) begin
               if (row_ff != y1_ff) begin
                  row_in      = row_ff + COORD_W'(1);
                  k_in        = k0;
                  row_base_in = row_base_ff + WPR_A;
                  addr_in     = row_base_ff + WPR_A + ADDR_W'(k0);
               end
            end else begin
               k_in    = k_ff + KW'(1);
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         grcc_pkg::ST_DRAIN: ;
         grcc_pkg::ST_FINISH: begin
            if (finish_go) begin
               rsp_valid_in = 1'b1;
               if (op_ff == grcc_pkg::OP_CLEAR) begin
                  free_count_in = wh_ff;
                  rsp_cov_in    = '0;
                  rsp_free_in   = CNT_W'(wh_ff);
               end else begin
                  free_count_in = free_next;
                  rsp_cov_in    = CNT_W'(acc_ff);
                  rsp_free_in   = CNT_W'(free_next);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= grcc_pkg::ST_SWEEP;
         addr_ff         <= '0;
         hw_ff           <= TOTAL_A;
         reply_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         free_count_ff   <= RESET_FREE;
         board_width_ff  <= grcc_pkg::BOARD_RESET;
         board_height_ff <= grcc_pkg::BOARD_RESET;
      end else begin
         state_ff        <= state_in;
         addr_ff         <= addr_in;
         hw_ff           <= hw_in;
         reply_ff        <= reply_in;
         rsp_valid_ff    <= rsp_valid_in;
         free_count_ff   <= free_count_in;
         board_width_ff  <= board_width_in;
         board_height_ff <= board_height_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      xa_ff       <= xa_in;
      ya_ff       <= ya_in;
      xb_ff       <= xb_in;
      yb_ff       <= yb_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      row_ff      <= row_in;
      k_ff        <= k_in;
      row_base_ff <= row_base_in;
      wh_ff       <= wh_in;
      acc_ff      <= acc_in;
      rsp_cov_ff  <= rsp_cov_in;
      rsp_free_ff <= rsp_free_in;
   end

   grcc_bitmap #(
      .DEPTH (TOTAL)
   ) u_bitmap (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .addr  (addr_ff),
      .mask  (mask),
      .stat  (stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_free_ff, rsp_cov_ff};

   a_no_accept_while_busy : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (!stat.busy && !stat.pop_valid))
      else $error("beat accepted while bitmap pipeline active");

   a_pop_range : assert property (@(posedge clock) disable iff (reset)
      stat.pop_valid |-> (stat.pop_count <= grcc_pkg::POP_W'(64)))
      else $error("word popcount above 64");

   a_clear_sweeps : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == grcc_pkg::OP_CLEAR)
         |-> ##2 (state_ff == grcc_pkg::ST_SWEEP))
      else $error("clear beat did not start a sweep");

   a_pop_in_walk : assert property (@(posedge clock) disable iff (reset)
      stat.pop_valid |-> (state_ff == grcc_pkg::ST_RUN || state_ff == grcc_pkg::ST_DRAIN))
      else $error("popcount outside rectangle walk");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned BOARD_MAX = grcc_pkg::MAX_SIDE_DEF;
   localparam int unsigned COORD_W = grcc_pkg::COORD_W;
   localparam int unsigned CNT_W = grcc_pkg::CNT_W;
   localparam int unsigned CSR_DATA_W = grcc_pkg::CSR_DATA_W;
   localparam int unsigned CSR_ADDR_W = grcc_pkg::CSR_ADDR_W;
   localparam int unsigned COORD_TOP = (1 << COORD_W) - 1;
   localparam int unsigned LONG_HOLD_CYCLES = 600;

   typedef struct {
      grcc_pkg::op_type   op;
      logic [COORD_W-1:0] x_first;
      logic [COORD_W-1:0] y_first;
      logic [COORD_W-1:0] x_second;
      logic [COORD_W-1:0] y_second;
   } board_item_type;

   typedef struct {
      logic [CNT_W-1:0] newly_covered;
      logic [CNT_W-1:0] free_cells;
   } cover_result_type;

   typedef enum int {
      SHAPE_SMALL,
      SHAPE_MEDIUM,
      SHAPE_WILD,
      SHAPE_OUTSIDE
   } shape_kind_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [grcc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [grcc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor state: one bit per cell, set when covered.
   logic [BOARD_MAX-1:0]   cell_rows [BOARD_MAX];
   int unsigned            free_left;
   logic [COORD_W-1:0]     board_width_q = grcc_pkg::BOARD_RESET;
   logic [COORD_W-1:0]     board_height_q = grcc_pkg::BOARD_RESET;

   board_item_type         item_queue [$];
   board_item_type         offered;
   cover_result_type       pending_results [$];

   int unsigned            send_idle_pct = 0;
   int unsigned            recv_stall_pct = 0;
   bit                     hold_armed = 1'b0;
   logic                   long_hold = 1'b0;
   int unsigned            mismatch_count = 0;
   int unsigned            clears_taken = 0;
   int unsigned            covers_taken = 0;
   int unsigned            results_seen = 0;

   grid_rectangle_cover_count_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      for (int r = 0; r < BOARD_MAX; r++) cell_rows[r] = '0;
      free_left = BOARD_MAX * BOARD_MAX;
   end

   // A register value of zero means one side cell; anything larger than the
   // bitmap is cut down to it.
   function automatic int unsigned effective_side(logic [COORD_W-1:0] v);
      if (v == 0) return 1;
      if (v > BOARD_MAX) return BOARD_MAX;
      return v;
   endfunction

   function automatic int unsigned clamp_coord(logic [COORD_W-1:0] v, int unsigned side);
      if (v == 0) return 1;
      if (v > side) return side;
      return v;
   endfunction

   function automatic cover_result_type apply_to_board(board_item_type item);
      int unsigned wd, ht, xa, ya, xb, yb, x_lo, x_hi, y_lo, y_hi, fresh;
      logic [BOARD_MAX-1:0] span;
      cover_result_type res;
      wd = effective_side(board_width_q);
      ht = effective_side(board_height_q);
      fresh = 0;
      if (item.op == grcc_pkg::OP_CLEAR) begin
         for (int r = 0; r < BOARD_MAX; r++) cell_rows[r] = '0;
         free_left = wd * ht;
      end else begin
         xa = clamp_coord(item.x_first, wd);
         ya = clamp_coord(item.y_first, ht);
         xb = clamp_coord(item.x_second, wd);
         yb = clamp_coord(item.y_second, ht);
         x_lo = ((xa < xb) ? xa : xb) - 1;
         x_hi = ((xa < xb) ? xb : xa) - 1;
         y_lo = ((ya < yb) ? ya : yb) - 1;
         y_hi = ((ya < yb) ? yb : ya) - 1;
         span = ({BOARD_MAX{1'b1}} >> (BOARD_MAX - 1 - x_hi)) & ({BOARD_MAX{1'b1}} << x_lo);
         for (int r = y_lo; r <= y_hi; r++) begin
            fresh += $countones(span & ~cell_rows[r]);
            cell_rows[r] |= span;
         end
         // The count saturates when the board grew after the last clear.
         free_left = (fresh > free_left) ? 0 : free_left - fresh;
      end
      res.newly_covered = CNT_W'(fresh);
      res.free_cells = CNT_W'(free_left);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            pending_results.push_back(apply_to_board(offered));
            if (offered.op == grcc_pkg::OP_CLEAR) clears_taken++;
            else covers_taken++;
         end
         if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offered = item_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {offered.y_second, offered.x_second, offered.y_first, offered.x_first};
            req_tuser <= offered.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cover_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("result beat with nothing expected: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[CNT_W-1:0] !== want.newly_covered) begin
                  $error("newly_covered: expected %0d, got %0d",
                         want.newly_covered, rsp_tdata[CNT_W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[2*CNT_W-1:CNT_W] !== want.free_cells) begin
                  $error("free_cells: expected %0d, got %0d",
                         want.free_cells, rsp_tdata[2*CNT_W-1:CNT_W]);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Long output stall so the block backs up and stops taking input.
   initial begin
      wait (hold_armed);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic queue_cover(int unsigned xa, int unsigned ya, int unsigned xb,
                              int unsigned yb);
      board_item_type item;
      item.op = grcc_pkg::OP_COVER;
      item.x_first = COORD_W'(xa);
      item.y_first = COORD_W'(ya);
      item.x_second = COORD_W'(xb);
      item.y_second = COORD_W'(yb);
      item_queue.push_back(item);
   endtask

   task automatic queue_clear();
      board_item_type item;
      item.op = grcc_pkg::OP_CLEAR;
      item.x_first = COORD_W'($urandom);
      item.y_first = COORD_W'($urandom);
      item.x_second = COORD_W'($urandom);
      item.y_second = COORD_W'($urandom);
      item_queue.push_back(item);
   endtask

   task automatic write_board(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      if (addr == grcc_pkg::CSR_BOARD_WIDTH) board_width_q = value;
      else board_height_q = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every item is taken and answered, then lets the block settle.
   task automatic settle_board();
      while (item_queue.size() != 0 || req_tvalid || pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic pick_pair(int unsigned side, shape_kind_type kind,
                            output logic [COORD_W-1:0] first,
                            output logic [COORD_W-1:0] second);
      int unsigned base, reach, lo, hi;
      logic [COORD_W-1:0] tmp;
      case (kind)
         SHAPE_SMALL, SHAPE_MEDIUM: begin
            reach = (kind == SHAPE_SMALL) ? 15 : 63;
            base = $urandom_range(side, 1);
            lo = (base > reach) ? base - reach : 1;
            hi = (base + reach < side) ? base + reach : side;
            first = COORD_W'(base);
            second = COORD_W'($urandom_range(hi, lo));
         end
         SHAPE_WILD: begin
            first = COORD_W'($urandom_range(COORD_TOP, 0));
            second = COORD_W'($urandom_range(COORD_TOP, 0));
         end
         default: begin
            first = $urandom_range(1) ? '0 : COORD_W'($urandom_range(COORD_TOP, side + 1));
            second = COORD_W'($urandom_range(side, 1));
         end
      endcase
      if ($urandom_range(1)) begin
         tmp = first;
         first = second;
         second = tmp;
      end
   endtask

   task automatic queue_random(int unsigned count);
      int unsigned wd, ht, roll;
      shape_kind_type kind;
      board_item_type item;
      wd = effective_side(board_width_q);
      ht = effective_side(board_height_q);
      queue_clear();
      for (int n = 1; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 5) begin
            queue_clear();
         end else begin
            if (roll < 70) kind = SHAPE_SMALL;
            else if (roll < 85) kind = SHAPE_MEDIUM;
            else if (roll < 92) kind = SHAPE_WILD;
            else kind = SHAPE_OUTSIDE;
            item.op = grcc_pkg::OP_COVER;
            pick_pair(wd, kind, item.x_first, item.x_second);
            pick_pair(ht, kind, item.y_first, item.y_second);
            item_queue.push_back(item);
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] widths [8];
      logic [CSR_DATA_W-1:0] heights [8];
      widths = '{10'd512, 10'd0, 10'd37, 10'd1023, 10'd1, 10'd200, 10'd64, 10'd0};
      heights = '{10'd512, 10'd1023, 10'd100, 10'd513, 10'd1, 10'd65, 10'd64, 10'd0};
      widths[7] = CSR_DATA_W'($urandom_range(COORD_TOP, 0));
      heights[7] = CSR_DATA_W'($urandom_range(COORD_TOP, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset board: corners in both orders, clamping at
      // both ends, a word boundary, and covering cells that are already covered.
      queue_cover(1, 1, 1, 1);
      queue_cover(512, 512, 1, 1);
      queue_cover(1, 1, 512, 512);
      queue_clear();
      queue_cover(0, 0, 3, 3);
      queue_cover(1023, 1023, 510, 511);
      queue_cover(64, 1, 65, 2);
      queue_cover(5, 300, 2, 200);
      queue_cover(1023, 0, 1023, 0);
      settle_board();

      // One-cell board, then grow it without a clear so the count bottoms out.
      write_board(grcc_pkg::CSR_BOARD_WIDTH, 10'd1);
      write_board(grcc_pkg::CSR_BOARD_HEIGHT, 10'd1);
      queue_clear();
      queue_cover(1, 1, 1023, 1023);
      queue_clear();
      settle_board();
      write_board(grcc_pkg::CSR_BOARD_WIDTH, 10'd512);
      write_board(grcc_pkg::CSR_BOARD_HEIGHT, 10'd512);
      queue_cover(512, 1, 1, 512);
      settle_board();

      // Register values out of range on each side.
      write_board(grcc_pkg::CSR_BOARD_WIDTH, 10'd0);
      write_board(grcc_pkg::CSR_BOARD_HEIGHT, 10'd1023);
      queue_clear();
      queue_cover(1, 1, 7, 600);
      queue_cover(2, 0, 0, 1023);
      settle_board();
      write_board(grcc_pkg::CSR_BOARD_WIDTH, 10'd513);
      write_board(grcc_pkg::CSR_BOARD_HEIGHT, 10'd1);
      queue_clear();
      queue_cover(600, 1, 1, 1);
      settle_board();

      for (int p = 0; p < 8; p++) begin
         write_board(grcc_pkg::CSR_BOARD_WIDTH, widths[p]);
         write_board(grcc_pkg::CSR_BOARD_HEIGHT, heights[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         if (p == 2) hold_armed = 1'b1;
         queue_random(145);
         settle_board();
      end

      repeat (100) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         mismatch_count++;
      end
      $display("Checked %0d results: %0d clears and %0d rectangles over 13 board settings,",
               results_seen, clears_taken, covers_taken);
      $display("with input gaps, output stalls and one long output hold-off.");
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
